@@ design/gmab_pkg.sv @@
package gmab_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_DRAW_COLOR    = 3'd0;
    localparam logic [2:0] REG_CLIP_LEFT     = 3'd1;
    localparam logic [2:0] REG_CLIP_TOP      = 3'd2;
    localparam logic [2:0] REG_CLIP_WIDTH    = 3'd3;
    localparam logic [2:0] REG_CLIP_HEIGHT   = 3'd4;
    localparam logic [2:0] REG_TARGET_WIDTH  = 3'd5;
    localparam logic [2:0] REG_TARGET_HEIGHT = 3'd6;
    localparam logic [2:0] REG_ROW_STRIDE    = 3'd7;

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0]  BYTE_MAX   = 8'hFF;
    localparam logic [16:0] ROUND_BIAS = 17'd127;

    // pipeline advance enables for the blend lanes
    typedef struct packed {
        logic s3;
        logic s4;
    } t_adv;

    // floor(v / 255) for v below 65280: (v + (v >> 8) + 1) >> 8
    function automatic logic [7:0] div255(input logic [16:0] v);
        logic [17:0] t;
        t = 18'(v) + 18'(v[16:8]) + 18'd1;
        return t[15:8];
    endfunction

endpackage

@@ design/gmab_chan.sv @@
module gmab_chan
    import gmab_pkg::*;
(
    input  logic       i_clk,
    input  t_adv       i_adv,
    input  logic [7:0] i_src,
    input  logic [7:0] i_dst,
    input  logic [7:0] i_sa,
    input  logic       i_ok,
    output logic [7:0] o_byte
);

    logic [16:0] r_sum;
    logic [16:0] n_sum;
    logic [7:0]  r_byte;

    // weighted sum with rounding bias, one stage
    always_comb begin
        n_sum = 17'(16'(i_src) * 16'(i_sa)) + 17'(16'(i_dst) * 16'(8'(BYTE_MAX - i_sa)))
              + ROUND_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_sum <= n_sum;
        end
    end

    // divide by 255; zero when the pixel is dropped
    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_byte <= i_ok ? div255(r_sum) : 8'd0;
        end
    end

    assign o_byte = r_byte;

endmodule

@@ design/glyph_mask_alpha_blend.sv @@
// Throughput: one word per cycle when the output is not stalled; four register stages
// (place, clip and scale with the offset multipliers, span check and blend products,
// divide) each advance on their own.
// Stalls back up stage by stage through a ready chain; nothing is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits and every configuration
// register to zero.
module glyph_mask_alpha_blend
    import gmab_pkg::*;
#(
    parameter int MAX_TARGET_DIM  = 4096,
    parameter int MAX_MASK_WIDTH  = 1024,
    parameter int MAX_MASK_HEIGHT = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_wr_en,
    input  logic [2:0]             i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // origin_x[15:0] origin_y[31:16] mask_col[41:32] mask_row[49:42] coverage[57:50]
    // old_red[65:58] old_green[73:66] old_blue[81:74] old_alpha[89:82] zero[95:90]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // pixel_x[11:0] pixel_y[23:12] new_red[31:24] new_green[39:32]
    // new_blue[47:40] new_alpha[55:48]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // write_pixel[0]
    output logic [OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int XW  = $clog2(MAX_TARGET_DIM);
    localparam int TDW = $clog2(MAX_TARGET_DIM + 1);
    localparam int YSW = XW + 16;
    localparam int SPW = TDW + 16;
    localparam int CW  = SPW + 1;

    // ---------------- configuration registers ----------------
    logic [31:0]        r_draw_color;
    logic signed [15:0] r_clip_left;
    logic signed [15:0] r_clip_top;
    logic signed [15:0] r_clip_width;
    logic signed [15:0] r_clip_height;
    logic [12:0]        r_target_width;
    logic [12:0]        r_target_height;
    logic [15:0]        r_row_stride;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_draw_color    <= '0;
            r_clip_left     <= '0;
            r_clip_top      <= '0;
            r_clip_width    <= '0;
            r_clip_height   <= '0;
            r_target_width  <= '0;
            r_target_height <= '0;
            r_row_stride    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_DRAW_COLOR:    r_draw_color    <= i_cfg_data;
                REG_CLIP_LEFT:     r_clip_left     <= i_cfg_data[15:0];
                REG_CLIP_TOP:      r_clip_top      <= i_cfg_data[15:0];
                REG_CLIP_WIDTH:    r_clip_width    <= i_cfg_data[15:0];
                REG_CLIP_HEIGHT:   r_clip_height   <= i_cfg_data[15:0];
                REG_TARGET_WIDTH:  r_target_width  <= i_cfg_data[12:0];
                REG_TARGET_HEIGHT: r_target_height <= i_cfg_data[12:0];
                REG_ROW_STRIDE:    r_row_stride    <= i_cfg_data[15:0];
            endcase
        end
    end

    logic [7:0] ga, cr, cg, cb;
    assign ga = r_draw_color[31:24];
    assign cr = r_draw_color[23:16];
    assign cg = r_draw_color[15:8];
    assign cb = r_draw_color[7:0];

    // saturated target size
    logic [TDW-1:0] tw_sat, th_sat;
    assign tw_sat = (32'(r_target_width) > MAX_TARGET_DIM) ? TDW'(MAX_TARGET_DIM)
                                                           : TDW'(r_target_width);
    assign th_sat = (32'(r_target_height) > MAX_TARGET_DIM) ? TDW'(MAX_TARGET_DIM)
                                                            : TDW'(r_target_height);

    // ---------------- ready chain ----------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;
    t_adv adv;

    assign rdy4 = !r_v4 || i_m_axis_tready;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign adv  = '{s3: rdy3, s4: rdy4};
    assign o_s_axis_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_s_axis_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // ---------------- stage 1: place pixel, coverage product ----------------
    logic signed [15:0] in_ox, in_oy;
    logic [9:0]         in_col;
    logic [7:0]         in_row, in_cov;

    assign in_ox  = i_s_axis_tdata[15:0];
    assign in_oy  = i_s_axis_tdata[31:16];
    assign in_col = i_s_axis_tdata[41:32];
    assign in_row = i_s_axis_tdata[49:42];
    assign in_cov = i_s_axis_tdata[57:50];

    logic signed [16:0] r1_x, r1_y;
    logic [9:0]         r1_col;
    logic [7:0]         r1_row;
    logic               r1_cov_nz;
    logic [15:0]        r1_prod;
    logic [31:0]        r1_old;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r1_x      <= {in_ox[15], in_ox} + $signed(17'(in_col));
            r1_y      <= {in_oy[15], in_oy} + $signed(17'(in_row));
            r1_col    <= in_col;
            r1_row    <= in_row;
            r1_cov_nz <= (in_cov != 8'd0);
            r1_prod   <= 16'(in_cov) * 16'(ga);
            r1_old    <= i_s_axis_tdata[89:58];
        end
    end

    // ---------------- stage 2: clip tests, scaled alpha, offset products ----------------
    logic signed [16:0] clip_l, clip_t, clip_r, clip_h, tw_s, th_s;
    logic               dis, out_lo, out_hi, s2_ok;
    logic [7:0]         s2_sa;

    assign clip_l = {r_clip_left[15], r_clip_left};
    assign clip_t = {r_clip_top[15], r_clip_top};
    assign clip_r = clip_l + {r_clip_width[15], r_clip_width};
    assign clip_h = {r_clip_height[15], r_clip_height};
    assign tw_s   = $signed(17'(tw_sat));
    assign th_s   = $signed(17'(th_sat));
    assign s2_sa  = div255(17'(r1_prod) + ROUND_BIAS);

    always_comb begin
        dis = (tw_sat == '0) || (th_sat == '0) || (r_row_stride == 16'd0)
           || (r_clip_width <= 16'sd0) || (r_clip_height <= 16'sd0) || (ga == 8'd0);
        out_lo = (r1_x < 17'sd0) || (r1_x < clip_l) || (r1_y < 17'sd0) || (r1_y < clip_t);
        out_hi = (32'(r1_col) >= MAX_MASK_WIDTH) || (r1_x >= clip_r) || (r1_x >= tw_s)
              || (32'(r1_row) >= MAX_MASK_HEIGHT) || ($signed(17'(r1_row)) >= clip_h)
              || (r1_y >= th_s);
        s2_ok = !dis && !out_lo && !out_hi && r1_cov_nz && (s2_sa != 8'd0);
    end

    logic           r2_ok;
    logic [XW-1:0]  r2_x, r2_y;
    logic [YSW-1:0] r2_ystride;
    logic [SPW-1:0] r2_span;
    logic [7:0]     r2_sa;
    logic [31:0]    r2_old;

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r2_ok      <= s2_ok;
            r2_x       <= r1_x[XW-1:0];
            r2_y       <= r1_y[XW-1:0];
            r2_ystride <= YSW'(r1_y[XW-1:0]) * YSW'(r_row_stride);
            r2_span    <= SPW'(r_row_stride) * SPW'(th_sat);
            r2_sa      <= s2_sa;
            r2_old     <= r1_old;
        end
    end

    // ---------------- stage 3: byte span check ----------------
    logic [CW-1:0] s3_last;
    assign s3_last = CW'(r2_ystride) + CW'({r2_x, 2'b11});

    logic          r3_ok;
    logic [XW-1:0] r3_x, r3_y;

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r3_ok <= r2_ok && (s3_last < CW'(r2_span));
            r3_x  <= r2_x;
            r3_y  <= r2_y;
        end
    end

    // ---------------- blend lanes: stages 3 and 4 ----------------
    logic [7:0] new_r, new_g, new_b, new_a;

    gmab_chan u_chan_r (
        .i_clk (i_clk), .i_adv (adv), .i_src (cr), .i_dst (r2_old[7:0]),
        .i_sa (r2_sa), .i_ok (r3_ok), .o_byte (new_r)
    );
    gmab_chan u_chan_g (
        .i_clk (i_clk), .i_adv (adv), .i_src (cg), .i_dst (r2_old[15:8]),
        .i_sa (r2_sa), .i_ok (r3_ok), .o_byte (new_g)
    );
    gmab_chan u_chan_b (
        .i_clk (i_clk), .i_adv (adv), .i_src (cb), .i_dst (r2_old[23:16]),
        .i_sa (r2_sa), .i_ok (r3_ok), .o_byte (new_b)
    );
    gmab_chan u_chan_a (
        .i_clk (i_clk), .i_adv (adv), .i_src (BYTE_MAX), .i_dst (r2_old[31:24]),
        .i_sa (r2_sa), .i_ok (r3_ok), .o_byte (new_a)
    );

    // ---------------- stage 4: output word ----------------
    logic        r4_write;
    logic [11:0] r4_px, r4_py;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r4_write <= r3_ok;
            r4_px    <= r3_ok ? 12'(r3_x) : 12'd0;
            r4_py    <= r3_ok ? 12'(r3_y) : 12'd0;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tuser  = r4_write;
    assign o_m_axis_tdata  = {new_a, new_b, new_g, new_r, r4_py, r4_px};

    // ---------------- assertions ----------------
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !r4_write) |-> (o_m_axis_tdata == '0))
        else $error("dropped pixel word carries nonzero data");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (r_v1 && r_v2 && r_v3 && r_v4 && !i_m_axis_tready))
        else $error("input stalled while the pipeline has room");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy3) |=> r_v3)
        else $error("stalled stage 3 word lost");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import gmab_pkg::*;

    localparam int TGT_DIM_MAX  = 4096;
    localparam int MASK_W_MAX   = 1024;
    localparam int MASK_H_MAX   = 256;
    localparam int RANDOM_WORDS = 1300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_TAIL   = 8;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [2:0]             cfg_index   = REG_DRAW_COLOR;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;

    always #5 i_clk = ~i_clk;

    glyph_mask_alpha_blend u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    typedef struct {
        logic       write;
        logic [11:0] px;
        logic [11:0] py;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_pixel;

    // blend predictor plus queue of pixels still owed by the block
    class blend_scoreboard;
        int unsigned color;
        int          clip_l, clip_t, clip_w, clip_h;
        int          tgt_w, tgt_h, stride;
        t_pixel      expected_pixels[$];
        int          errors, n_results, n_written;

        function void set_reg(logic [2:0] idx, logic [31:0] d);
            case (idx)
                REG_DRAW_COLOR:    color  = d;
                REG_CLIP_LEFT:     clip_l = int'($signed(d[15:0]));
                REG_CLIP_TOP:      clip_t = int'($signed(d[15:0]));
                REG_CLIP_WIDTH:    clip_w = int'($signed(d[15:0]));
                REG_CLIP_HEIGHT:   clip_h = int'($signed(d[15:0]));
                REG_TARGET_WIDTH:  tgt_w  = int'(d[12:0]);
                REG_TARGET_HEIGHT: tgt_h  = int'(d[12:0]);
                REG_ROW_STRIDE:    stride = int'(d[15:0]);
                default: ;
            endcase
        endfunction

        // rounded source-over of one channel
        function logic [7:0] mix_channel(int src, int dst, int a);
            return 8'((src * a + dst * (255 - a) + 127) / 255);
        endfunction

        function t_pixel predict_pixel(logic [IN_TDATA_W-1:0] w);
            t_pixel p;
            int     ox, oy, col, row, cov, ga, tw, th, x, y, sa;
            longint off, span;
            logic   ok;
            ox  = int'($signed(w[15:0]));
            oy  = int'($signed(w[31:16]));
            col = int'(w[41:32]);
            row = int'(w[49:42]);
            cov = int'(w[57:50]);
            ga  = int'(color[31:24]);
            tw  = (tgt_w > TGT_DIM_MAX) ? TGT_DIM_MAX : tgt_w;
            th  = (tgt_h > TGT_DIM_MAX) ? TGT_DIM_MAX : tgt_h;
            x   = ox + col;
            y   = oy + row;
            sa  = 0;
            p   = '{default: '0};
            ok  = 1'b1;
            if (tw == 0 || th == 0 || stride == 0 || clip_w <= 0 || clip_h <= 0 || ga == 0)
                ok = 1'b0;
            if (x < 0 || x < clip_l || y < 0 || y < clip_t)
                ok = 1'b0;
            // bottom edge counts from the origin row, not from clip top
            if (col >= MASK_W_MAX || x >= clip_l + clip_w || x >= tw)
                ok = 1'b0;
            if (row >= MASK_H_MAX || row >= clip_h || y >= th)
                ok = 1'b0;
            if (ok) begin
                sa = (cov * ga + 127) / 255;
                if (cov == 0 || sa == 0)
                    ok = 1'b0;
            end
            if (ok) begin
                off  = longint'(y) * stride + longint'(x) * 4;
                span = longint'(stride) * th;
                if (off + 3 >= span)
                    ok = 1'b0;
            end
            if (ok) begin
                p.write = 1'b1;
                p.px    = x[11:0];
                p.py    = y[11:0];
                if (sa == 255) begin
                    p.r = color[23:16];
                    p.g = color[15:8];
                    p.b = color[7:0];
                    p.a = 8'hFF;
                end else begin
                    p.r = mix_channel(color[23:16], w[65:58], sa);
                    p.g = mix_channel(color[15:8], w[73:66], sa);
                    p.b = mix_channel(color[7:0], w[81:74], sa);
                    p.a = mix_channel(255, w[89:82], sa);
                end
            end
            return p;
        endfunction

        task note_input(logic [IN_TDATA_W-1:0] w);
            t_pixel p;
            p = predict_pixel(w);
            expected_pixels.push_back(p);
            if (p.write)
                n_written++;
        endtask

        task report(string field, int got, int want);
            errors++;
            if (errors <= 40)
                $display("tb: mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
                         field, n_results, got, want);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
            t_pixel p;
            if (expected_pixels.size() == 0) begin
                report("word with nothing pending", int'(d[23:0]), 0);
                return;
            end
            p = expected_pixels.pop_front();
            n_results++;
            if (u[0] !== p.write)      report("write_pixel", u[0], p.write);
            if (d[11:0] !== p.px)      report("pixel_x", d[11:0], p.px);
            if (d[23:12] !== p.py)     report("pixel_y", d[23:12], p.py);
            if (d[31:24] !== p.r)      report("new_red", d[31:24], p.r);
            if (d[39:32] !== p.g)      report("new_green", d[39:32], p.g);
            if (d[47:40] !== p.b)      report("new_blue", d[47:40], p.b);
            if (d[55:48] !== p.a)      report("new_alpha", d[55:48], p.a);
        endtask

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    blend_scoreboard sb;
    int burst_left = 0;
    int settings   = 0;
    int idle_cycles = 0;
    int stall_tick  = 0;
    int stall_mode  = 0;

    // output side: stall pattern whose mode is re-picked at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 63)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_tick % 3 == 0);
        endcase
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: watchdog, no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic logic [IN_TDATA_W-1:0] pixel_word(int ox, int oy, int col, int row,
                                                         int cov, logic [31:0] old_abgr);
        // old_abgr: red in the low byte, alpha in the high byte
        return {6'b0, old_abgr, 8'(cov), 8'(row), 10'(col), 16'(oy), 16'(ox)};
    endfunction

    // one word, with burst/gap shaping on the input side
    task automatic send_word(input logic [IN_TDATA_W-1:0] w);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                       : $urandom_range(1, 16);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_input(w);
    endtask

    task automatic idle_until_drained(input int tail);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (tail) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
    endtask

    task automatic apply_setting(input logic [31:0] color, input int cl, input int ct,
                                 input int cw, input int ch, input int tw, input int th,
                                 input int stride);
        cfg_write(REG_DRAW_COLOR, color);
        cfg_write(REG_CLIP_LEFT, {16'b0, 16'(cl)});
        cfg_write(REG_CLIP_TOP, {16'b0, 16'(ct)});
        cfg_write(REG_CLIP_WIDTH, {16'b0, 16'(cw)});
        cfg_write(REG_CLIP_HEIGHT, {16'b0, 16'(ch)});
        cfg_write(REG_TARGET_WIDTH, {19'b0, 13'(tw)});
        cfg_write(REG_TARGET_HEIGHT, {19'b0, 13'(th)});
        cfg_write(REG_ROW_STRIDE, {16'b0, 16'(stride)});
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // edge signed 16-bit value, random one, or small value near zero
    function automatic int pick_clip_edge();
        case ($urandom_range(0, 15))
            0:       return -32768;
            1:       return 32767;
            2:       return int'($signed(16'($urandom)));
            default: return int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    function automatic int pick_target_dim();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 4096;
            2:       return 8191;
            3:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // one register setting, then mostly placed pixels with some raw noise
    task automatic random_phase(input int n_items, input logic force_hold);
        logic [31:0]           color;
        logic [IN_TDATA_W-1:0] w;
        int tw, th, xs, ys, stride, cl, ct, cw, ch, x, y, col, row, cov, hold_at;
        tw = pick_target_dim();
        th = pick_target_dim();
        xs = (tw == 0) ? 16 : ((tw > TGT_DIM_MAX) ? TGT_DIM_MAX : tw);
        ys = (th == 0) ? 16 : ((th > TGT_DIM_MAX) ? TGT_DIM_MAX : th);
        case ($urandom_range(0, 15))
            0:       stride = 0;
            1:       stride = 65535;
            2:       stride = $urandom_range(0, 65535);
            3:       stride = 4 * xs - int'($urandom_range(1, 2 * xs));
            default: stride = 4 * xs + int'($urandom_range(0, 12));
        endcase
        case ($urandom_range(0, 15))
            0:       color = {8'h00, 24'($urandom)};
            1:       color = 32'hFFFF_FFFF;
            2:       color = 32'h0000_0000;
            3:       color = {8'hFF, 24'($urandom)};
            4:       color = {8'h01, 24'($urandom)};
            default: color = $urandom;
        endcase
        cl = pick_clip_edge();
        ct = pick_clip_edge();
        case ($urandom_range(0, 15))
            0:       cw = 0;
            1:       cw = -int'($urandom_range(1, 300));
            2:       cw = 32767;
            3:       cw = -32768;
            default: cw = xs - cl + int'($urandom_range(0, 3)) - 2;
        endcase
        case ($urandom_range(0, 15))
            0:       ch = 0;
            1:       ch = -int'($urandom_range(1, 300));
            2:       ch = 32767;
            3:       ch = -32768;
            default: ch = $urandom_range(1, 70);
        endcase
        apply_setting(color, cl, ct, cw, ch, tw, th, stride);

        hold_at = (force_hold || $urandom_range(0, 2) == 0) ? n_items / 2 : -1;
        for (int i = 0; i < n_items; i++) begin
            // sender holds back until the pipeline has emptied
            if (i == hold_at)
                idle_until_drained($urandom_range(1, 3));
            if ($urandom_range(0, 4) == 0) begin
                w = {6'b0, 26'($urandom), $urandom, $urandom};
            end else begin
                x   = int'($urandom_range(0, xs + 3)) - 2;
                y   = int'($urandom_range(0, ys + 3)) - 2;
                col = $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
                row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 63);
                case ($urandom_range(0, 7))
                    0:       cov = 0;
                    1:       cov = 255;
                    default: cov = $urandom_range(0, 255);
                endcase
                w = pixel_word(x - col, y - row, col, row, cov, $urandom);
            end
            send_word(w);
        end
    endtask

    initial begin
        int sent;
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: everything disabled
        send_word(pixel_word(0, 0, 0, 0, 255, 32'hFFFF_FFFF));
        send_word(pixel_word(3, 2, 1, 1, 128, 32'h1234_5678));
        idle_until_drained(DRAIN_TAIL);

        // small target with an offset clip window, full color alpha
        apply_setting(32'hFF20_4080, 2, 1, 40, 20, 32, 16, 128);
        send_word(pixel_word(0, 0, 5, 3, 255, 32'h8040_2010));       // opaque replace
        send_word(pixel_word(0, 0, 5, 3, 0, 32'h8040_2010));         // zero coverage
        send_word(pixel_word(0, 0, 5, 3, 128, 32'hFFFF_FFFF));       // blend
        send_word(pixel_word(0, 0, 6, 4, 1, 32'h0000_0000));
        send_word(pixel_word(1, 1, 0, 0, 200, 32'h1122_3344));       // left of clip
        send_word(pixel_word(0, 0, 2, 1, 77, 32'h5566_7788));        // top-left corner
        send_word(pixel_word(0, 0, 3, 0, 77, 32'h5566_7788));        // above clip
        send_word(pixel_word(0, 0, 31, 2, 90, 32'h99AA_BBCC));       // last column
        send_word(pixel_word(0, 0, 32, 2, 90, 32'h99AA_BBCC));       // past target width
        send_word(pixel_word(0, 0, 4, 15, 90, 32'hDDEE_FF00));       // last row
        send_word(pixel_word(0, 0, 4, 16, 90, 32'hDDEE_FF00));       // past target height
        send_word(pixel_word(0, -10, 4, 19, 90, 32'h0102_0304));     // bottom edge from origin
        send_word(pixel_word(0, -10, 4, 20, 90, 32'h0102_0304));
        send_word(pixel_word(-5, 0, 3, 2, 90, 32'h0506_0708));       // negative x
        send_word(pixel_word(-1000, 0, 1023, 2, 99, 32'hF0E0_D0C0)); // widest mask column
        send_word(pixel_word(-32768, 32767, 1023, 255, 255, 32'hFFFF_FFFF));
        send_word(pixel_word(32767, -32768, 0, 0, 1, 32'h0000_0000));
        idle_until_drained(DRAIN_TAIL);

        // faint color and a stride shorter than a row: rounding and byte span
        apply_setting(32'h01FF_FFFF, 2, 1, 40, 20, 32, 16, 100);
        send_word(pixel_word(0, 0, 5, 3, 255, 32'h0000_0000));
        send_word(pixel_word(0, 0, 5, 3, 127, 32'h0000_0000));       // rounds to nothing
        send_word(pixel_word(0, 0, 25, 15, 255, 32'h4040_4040));     // beyond byte span
        send_word(pixel_word(0, 0, 24, 15, 255, 32'h4040_4040));
        idle_until_drained(DRAIN_TAIL);

        // oversized target saturates, widest stride
        apply_setting(32'hFFFF_FFFF, 0, 0, 32767, 32767, 8191, 4097, 65535);
        send_word(pixel_word(4000, 4000, 95, 95, 255, 32'h0000_0000));
        send_word(pixel_word(4001, 4000, 95, 95, 255, 32'h0000_0000));
        send_word(pixel_word(4000, 4001, 95, 95, 10, 32'h0000_0000));
        idle_until_drained(DRAIN_TAIL);

        // random settings, each followed by a batch of pixels
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            int n;
            n = $urandom_range(30, 90);
            random_phase(n, sent == 0);
            sent += n;
            idle_until_drained(DRAIN_TAIL);
        end

        idle_until_drained(12);
        $display("tb: %0d pixel words checked, %0d of them written to the target",
                 sb.n_results, sb.n_written);
        $display("tb: %0d register settings incl. disabled, saturated and extreme clips",
                 settings);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
